// ----- sv/spo2_pkg.sv -----
// Shared types and constants for the SpO2 / heart-rate estimator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spo2_pkg;

  localparam int MAX_SAMPLES = 128;
  localparam int SAMPLE_BITS = 18;
  localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int TOTAL_BITS  = SAMPLE_BITS + IDX_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + CNT_BITS;
  localparam int DEV_BITS    = PROD_BITS + IDX_BITS;
  localparam int WIDE_BITS   = 64;

  localparam int SPO2_BITS   = 7;
  localparam int RATE_BITS   = 10;
  localparam int DIVD_BITS   = 17;

  localparam logic [SPO2_BITS-1:0] SPO2_MAX  = 7'd100;
  localparam logic [SPO2_BITS-1:0] SPO2_BASE = 7'd104;
  localparam logic [10:0]          BEAT_SCALE = 11'd1500;

  typedef struct packed {
    logic [IDX_BITS-1:0] gaps;
    logic [IDX_BITS-1:0] gap_sum;
  } peak_stats_t;

  typedef struct packed {
    logic [SPO2_BITS-1:0] oxygen;
    logic                 sat_valid;
    logic [RATE_BITS-1:0] rate;
    logic                 pulse_valid;
  } result_t;

endpackage

// ----- sv/spo2_dev_lane.sv -----
// One deviation lane: accumulates sum |n*x - S| over a streamed window.
// Depends on spo2_pkg.
`timescale 1ns / 1ps

module spo2_dev_lane (
  input  logic                              clk,
  input  logic                              clear,
  input  logic                              vld,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0]  x,
  input  logic [spo2_pkg::CNT_BITS-1:0]     n,
  input  logic [spo2_pkg::TOTAL_BITS-1:0]   total,
  output logic [spo2_pkg::DEV_BITS-1:0]     dev
);

  logic [spo2_pkg::PROD_BITS-1:0] prod;
  logic [spo2_pkg::PROD_BITS-1:0] tot_ext;
  logic [spo2_pkg::PROD_BITS-1:0] diff;

  assign prod    = spo2_pkg::PROD_BITS'(n) * spo2_pkg::PROD_BITS'(x);
  assign tot_ext = spo2_pkg::PROD_BITS'(total);
  assign diff    = (prod >= tot_ext) ? (prod - tot_ext) : (tot_ext - prod);

  always_ff @(posedge clk) begin
    if (clear) begin
      dev <= '0;
    end else if (vld) begin
      dev <= dev + spo2_pkg::DEV_BITS'(diff);
    end
  end

endmodule

// ----- sv/spo2_peak_track.sv -----
// Peak lane: finds strict local IR maxima above the mean in a streamed
// window and keeps interval count and sum. Depends on spo2_pkg.
`timescale 1ns / 1ps

module spo2_peak_track (
  input  logic                              clk,
  input  logic                              clear,
  input  logic                              vld,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0]  x,
  input  logic [spo2_pkg::CNT_BITS-1:0]     n,
  input  logic [spo2_pkg::TOTAL_BITS-1:0]   total,
  output spo2_pkg::peak_stats_t             stats
);

  logic [spo2_pkg::SAMPLE_BITS-1:0] mid;
  logic [spo2_pkg::SAMPLE_BITS-1:0] left;
  logic [spo2_pkg::CNT_BITS-1:0]    seen;
  logic [spo2_pkg::IDX_BITS-1:0]    prev_peak;
  logic                             have_peak;
  logic [spo2_pkg::PROD_BITS-1:0]   scaled;
  logic [spo2_pkg::IDX_BITS-1:0]    cand_idx;
  logic                             is_peak;

  assign scaled   = spo2_pkg::PROD_BITS'(n) * spo2_pkg::PROD_BITS'(mid);
  assign cand_idx = spo2_pkg::IDX_BITS'(seen - 1'b1);
  assign is_peak  = (seen >= spo2_pkg::CNT_BITS'(2)) && (mid > left) && (mid > x) &&
                    (scaled > spo2_pkg::PROD_BITS'(total));

  always_ff @(posedge clk) begin
    if (clear) begin
      seen          <= '0;
      have_peak     <= 1'b0;
      stats.gaps    <= '0;
      stats.gap_sum <= '0;
    end else if (vld) begin
      left <= mid;
      mid  <= x;
      seen <= seen + 1'b1;
      if (is_peak) begin
        if (have_peak) begin
          stats.gap_sum <= stats.gap_sum + (cand_idx - prev_peak);
          stats.gaps    <= stats.gaps + 1'b1;
        end
        have_peak <= 1'b1;
        prev_peak <= cand_idx;
      end
    end
  end

endmodule

// ----- sv/spo2_merge.sv -----
// Merge stage: ratio-of-ratios SpO2 search and peak-interval rate divide.
// Depends on spo2_pkg.
`timescale 1ns / 1ps

module spo2_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [spo2_pkg::DEV_BITS-1:0]    d_ir,
  input  logic [spo2_pkg::DEV_BITS-1:0]    d_red,
  input  logic [spo2_pkg::TOTAL_BITS-1:0]  s_ir,
  input  logic [spo2_pkg::TOTAL_BITS-1:0]  s_red,
  input  spo2_pkg::peak_stats_t            stats,
  output logic                             done,
  output spo2_pkg::result_t                result
);

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_MUL    = 6'b000010,
    M_SCALE  = 6'b000100,
    M_SEARCH = 6'b001000,
    M_DIV    = 6'b010000,
    M_FIN    = 6'b100000
  } mstate_t;

  mstate_t state;

  logic [spo2_pkg::DEV_BITS-1:0]   di, dr;
  logic [spo2_pkg::TOTAL_BITS-1:0] si, sr;
  logic [spo2_pkg::WIDE_BITS-1:0]  num_p, den, num, m;
  logic [spo2_pkg::SPO2_BITS-1:0]  k;
  logic [spo2_pkg::DIVD_BITS-1:0]  quo;
  logic [spo2_pkg::IDX_BITS-1:0]   rem, divisor;
  logic [4:0]                      bits_left;
  logic [spo2_pkg::IDX_BITS:0]     trial;

  assign trial = {rem, quo[spo2_pkg::DIVD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == M_FIN);
      unique case (state)
        M_IDLE: begin
          if (start) begin
            di <= d_ir; dr <= d_red; si <= s_ir; sr <= s_red;
            divisor <= stats.gap_sum;
            quo <= spo2_pkg::DIVD_BITS'(spo2_pkg::BEAT_SCALE) *
                   spo2_pkg::DIVD_BITS'(stats.gaps);
            rem <= '0;
            bits_left <= 5'(spo2_pkg::DIVD_BITS);
            if (d_ir == '0 || s_red == '0) begin
              result <= '0;
              state  <= M_FIN;
            end else begin
              result.pulse_valid <= (stats.gaps != '0);
              result.sat_valid   <= 1'b1;
              state <= M_MUL;
            end
          end
        end
        M_MUL: begin
          num_p <= spo2_pkg::WIDE_BITS'(dr) * spo2_pkg::WIDE_BITS'(si);
          den   <= spo2_pkg::WIDE_BITS'(sr) * spo2_pkg::WIDE_BITS'(di);
          state <= M_SCALE;
        end
        M_SCALE: begin
          // 17*num, and the threshold for k = 100 is 4*den
          num   <= (num_p << 4) + num_p;
          m     <= den << 2;
          k     <= spo2_pkg::SPO2_MAX;
          state <= M_SEARCH;
        end
        M_SEARCH: begin
          if (num <= m) begin
            result.oxygen <= k;
            state <= M_DIV;
          end else if (k == spo2_pkg::SPO2_BITS'(1)) begin
            result.oxygen <= '0;
            state <= M_DIV;
          end else begin
            k <= k - 1'b1;
            m <= m + den;
          end
        end
        M_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= spo2_pkg::IDX_BITS'(trial - {1'b0, divisor});
            quo <= {quo[spo2_pkg::DIVD_BITS-2:0], 1'b1};
          end else begin
            rem <= trial[spo2_pkg::IDX_BITS-1:0];
            quo <= {quo[spo2_pkg::DIVD_BITS-2:0], 1'b0};
          end
          bits_left <= bits_left - 1'b1;
          if (bits_left == 5'd1) state <= M_FIN;
        end
        M_FIN: begin
          if (result.pulse_valid && result.sat_valid) begin
            result.rate <= quo[spo2_pkg::RATE_BITS-1:0];
          end else begin
            result.rate        <= '0;
            result.pulse_valid <= 1'b0;
          end
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/spo2_heart_rate_estimator_top.sv -----
// Top level of the SpO2 / heart-rate estimator: sample store, scan control,
// output register. Depends on spo2_pkg, spo2_dev_lane, spo2_peak_track, spo2_merge.
`timescale 1ns / 1ps

// Channel | Handshake               | Word
// --------+-------------------------+-------------------------------------------
// input   | in_valid / in_ready     | ir_sample, red_sample, last_sample
// output  | out_valid / out_ready   | oxygen_saturation, saturation_valid,
//         |                         | pulse_rate, pulse_valid
//
// Samples load one per cycle while the block is collecting a window.
// A word with last_sample closes the window: a scan of the n stored samples
// (one store read port), the SpO2 search (one 64-bit add and compare per
// step) and a bit-serial rate divide follow; in_ready is low until the result
// sits in the output register.
// Loading resumes while that result waits for out_ready.
// rst (synchronous) empties the window; stored samples are not cleared.

module spo2_heart_rate_estimator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0] ir_sample,
  input  logic [spo2_pkg::SAMPLE_BITS-1:0] red_sample,
  input  logic                             last_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spo2_pkg::SPO2_BITS-1:0]   oxygen_saturation,
  output logic                             saturation_valid,
  output logic [spo2_pkg::RATE_BITS-1:0]   pulse_rate,
  output logic                             pulse_valid
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state;

  // sample stores
  logic [spo2_pkg::SAMPLE_BITS-1:0] ir_mem  [spo2_pkg::MAX_SAMPLES];
  logic [spo2_pkg::SAMPLE_BITS-1:0] red_mem [spo2_pkg::MAX_SAMPLES];
  logic [spo2_pkg::SAMPLE_BITS-1:0] ir_q, red_q;

  logic [spo2_pkg::CNT_BITS-1:0]   sample_count;
  logic [spo2_pkg::TOTAL_BITS-1:0] ir_total, red_total;
  logic [spo2_pkg::CNT_BITS-1:0]   scan_idx;
  logic                            rd_vld;
  logic                            accept, has_room, scan_clear, merge_start, merge_done;

  logic [spo2_pkg::DEV_BITS-1:0] d_ir, d_red;
  spo2_pkg::peak_stats_t         stats;
  spo2_pkg::result_t             result;

  assign in_ready    = (state == ST_LOAD);
  assign accept      = in_valid && in_ready;
  assign has_room    = (sample_count < spo2_pkg::CNT_BITS'(spo2_pkg::MAX_SAMPLES));
  assign scan_clear  = accept && last_sample;
  assign merge_start = (state == ST_SCAN) && (scan_idx == sample_count) && !rd_vld;

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      ir_mem[sample_count[spo2_pkg::IDX_BITS-1:0]]  <= ir_sample;
      red_mem[sample_count[spo2_pkg::IDX_BITS-1:0]] <= red_sample;
    end
    if (state == ST_SCAN && scan_idx != sample_count) begin
      ir_q  <= ir_mem[scan_idx[spo2_pkg::IDX_BITS-1:0]];
      red_q <= red_mem[scan_idx[spo2_pkg::IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      sample_count <= '0;
      ir_total     <= '0;
      red_total    <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // store data is valid the cycle after each scan read
      rd_vld <= (state == ST_SCAN) && (scan_idx != sample_count);
      if (out_valid && out_ready && state != ST_HOLD) out_valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept && has_room) begin
            sample_count <= sample_count + 1'b1;
            ir_total     <= ir_total + spo2_pkg::TOTAL_BITS'(ir_sample);
            red_total    <= red_total + spo2_pkg::TOTAL_BITS'(red_sample);
          end
          if (scan_clear) begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx != sample_count) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!rd_vld) begin
            // merge has latched totals; the next window starts empty
            sample_count <= '0;
            ir_total     <= '0;
            red_total    <= '0;
            state        <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (merge_done) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            oxygen_saturation <= result.oxygen;
            saturation_valid  <= result.sat_valid;
            pulse_rate        <= result.rate;
            pulse_valid       <= result.pulse_valid;
            out_valid         <= 1'b1;
            state             <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  spo2_dev_lane u_ir_lane (
    .clk   (clk),
    .clear (scan_clear),
    .vld   (rd_vld),
    .x     (ir_q),
    .n     (sample_count),
    .total (ir_total),
    .dev   (d_ir)
  );

  spo2_dev_lane u_red_lane (
    .clk   (clk),
    .clear (scan_clear),
    .vld   (rd_vld),
    .x     (red_q),
    .n     (sample_count),
    .total (red_total),
    .dev   (d_red)
  );

  spo2_peak_track u_peak (
    .clk   (clk),
    .clear (scan_clear),
    .vld   (rd_vld),
    .x     (ir_q),
    .n     (sample_count),
    .total (ir_total),
    .stats (stats)
  );

  spo2_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (merge_start),
    .d_ir   (d_ir),
    .d_red  (d_red),
    .s_ir   (ir_total),
    .s_red  (red_total),
    .stats  (stats),
    .done   (merge_done),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= spo2_pkg::CNT_BITS'(spo2_pkg::MAX_SAMPLES))
    else $error("window count past capacity");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_spo2_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> oxygen_saturation <= spo2_pkg::SPO2_MAX &&
                  (saturation_valid || oxygen_saturation == '0))
    else $error("SpO2 out of range or set while invalid");

  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulse_valid |-> pulse_rate == '0)
    else $error("pulse rate set while invalid");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> !in_ready)
    else $error("input taken during scan");
`endif

endmodule
